// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk with reset arst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Expression never holds at a clock edge outside reset.
`define ASSERT_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

// ----- sv/scdp_pkg.sv -----
// ----------------------------------------------------------------------------
// S-curve planner package
// Widths and default parameter values shared by the planner modules.
// ----------------------------------------------------------------------------
package scdp_pkg;
	localparam int Q_W = 32;
	localparam int FRAC_BITS_DEF = 16;
	localparam int BISECT_STEPS_DEF = 32;
	localparam logic [Q_W-1:0] Q_MAX = '1;
endpackage

// ----- sv/s_curve_distance_planner.sv -----
// ----------------------------------------------------------------------------
// S-curve distance planner
// Plans a jerk-limited move from a start speed over a distance to rest, with
// a cruise at the speed limit when it fits and a bisection on peak speed
// otherwise. One sequencer drives a shared multiplier, divider and root unit.
// ----------------------------------------------------------------------------
//   channel   signals                          direction
//   input     in_valid, in_ready, 2 fields     into block
//   result    out_valid, out_ready, 12 fields  out of block
//   config    cfg_we, cfg_index, cfg_data      into block
//
// Each peak trial solves two segments with up to two divides each on the bit-serial divider.
// in_ready is high only while the sequencer is idle; a waiting result does
// not block a new item. Reset clears the sequencer and loads the limits to 1.0.
module s_curve_distance_planner
	import scdp_pkg::*;
#(
	parameter int BISECT_STEPS = BISECT_STEPS_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic [Q_W-1:0] start_speed,
	input  logic [Q_W-1:0] move_distance,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [Q_W-1:0] peak_speed,
	output logic [Q_W-1:0] cruise_time,
	output logic [Q_W-1:0] accel_jerk_time,
	output logic [Q_W-1:0] accel_const_time,
	output logic [Q_W-1:0] decel_jerk_time,
	output logic [Q_W-1:0] decel_const_time,
	output logic           accel_hit_limit,
	output logic           decel_hit_limit,
	output logic [Q_W-1:0] accel_distance,
	output logic [Q_W-1:0] decel_distance,
	output logic [Q_W-1:0] total_distance,
	output logic [Q_W-1:0] total_time,
	input  logic           cfg_we,
	input  logic [1:0]     cfg_index,
	input  logic [Q_W-1:0] cfg_data
);
	`include "assert_macros.svh"

	localparam logic [1:0] REG_SPEED = 2'd0;
	localparam logic [1:0] REG_ACCEL = 2'd1;
	localparam logic [1:0] REG_JERK = 2'd2;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_TRI_MUL = 4'd1;
	localparam logic [3:0] ST_TRI_DIV = 4'd2;
	localparam logic [3:0] ST_TRI_WAIT = 4'd3;
	localparam logic [3:0] ST_SG_START = 4'd4;
	localparam logic [3:0] ST_SG_WAIT1 = 4'd5;
	localparam logic [3:0] ST_SG_WAIT2 = 4'd6;
	localparam logic [3:0] ST_SG_SQRT = 4'd7;
	localparam logic [3:0] ST_SG_DUR = 4'd8;
	localparam logic [3:0] ST_SG_MUL = 4'd9;
	localparam logic [3:0] ST_SG_DIST = 4'd10;
	localparam logic [3:0] ST_EVAL = 4'd11;
	localparam logic [3:0] ST_TC_WAIT = 4'd12;
	localparam logic [3:0] ST_VT_MUL = 4'd13;
	localparam logic [3:0] ST_TOT = 4'd14;
	localparam logic [3:0] ST_DONE = 4'd15;

	localparam logic [1:0] PH_CHECK = 2'd0;
	localparam logic [1:0] PH_BISECT = 2'd1;
	localparam logic [1:0] PH_FINAL = 2'd2;

	localparam int KW = $clog2(BISECT_STEPS + 1);
	localparam logic [Q_W-1:0] Q_ONE = Q_W'(1) << FRAC_BITS;

	function automatic logic [Q_W-1:0] q_mid(input logic [Q_W-1:0] x, input logic [Q_W-1:0] y);
		logic [Q_W:0] s;
		s = {1'b0, x} + {1'b0, y};
		return s[Q_W:1];
	endfunction

	function automatic logic [Q_W-1:0] q_sat(input logic [Q_W+1:0] v);
		return (|v[Q_W+1:Q_W]) ? Q_MAX : v[Q_W-1:0];
	endfunction

	logic [3:0]     state_q;
	logic [1:0]     phase_q;
	logic [Q_W-1:0] max_speed_q, max_accel_q, max_jerk_q;
	logic [Q_W-1:0] v0_q, len_q, a_q, j_q, tri_q;
	logic [Q_W-1:0] vp_q, lo_q, hi_q, vc_q, tc_q;
	logic [KW-1:0]  k_q;
	logic [Q_W-1:0] seg_p_q, seg_v_q, seg_jt_q, seg_ct_q, seg_dur_q;
	logic           seg_hit_q, seg_sel_q;
	logic [Q_W-1:0] up_jt_q, up_ct_q, up_dur_q, up_dist_q;
	logic [Q_W-1:0] dn_jt_q, dn_ct_q, dn_dur_q, dn_dist_q;
	logic           up_hit_q, dn_hit_q;
	logic [Q_W-1:0] tot_d_q, tot_t_q;
	logic [2*Q_W-1:0] prod_q;
	logic           out_valid_q;

	logic [Q_W-1:0] seg_lo, seg_hi, seg_dv, seg_mid, mul_res, d_sum;
	logic [Q_W-1:0] mul_a, mul_b, div_num, div_den, sqrt_x;
	logic [Q_W-1:0] init_lo, init_hi, bis_lo, bis_hi;
	logic [2*Q_W-1:0] prod_sh;
	logic           div_start, div_busy, div_done, sqrt_start, sqrt_busy, sqrt_done;
	logic [Q_W-1:0] div_quo, sqrt_root;
	logic           fits_cruise;

	assign seg_lo = (seg_p_q < seg_v_q) ? seg_p_q : seg_v_q;
	assign seg_hi = (seg_p_q < seg_v_q) ? seg_v_q : seg_p_q;
	assign seg_dv = seg_hi - seg_lo;
	assign seg_mid = seg_lo + (seg_dv >> 1);
	assign prod_sh = prod_q >> FRAC_BITS;
	assign mul_res = (|prod_sh[2*Q_W-1:Q_W]) ? Q_MAX : prod_sh[Q_W-1:0];
	assign d_sum = q_sat({2'b00, up_dist_q} + {2'b00, dn_dist_q});
	assign fits_cruise = len_q > d_sum;
	assign init_lo = (v0_q == '0) ? Q_W'(1) : v0_q;
	assign init_hi = (max_speed_q > init_lo) ? max_speed_q : init_lo;
	assign bis_lo = (d_sum < len_q) ? vp_q : lo_q;
	assign bis_hi = (d_sum < len_q) ? hi_q : vp_q;

	always_comb begin
		case (state_q)
			ST_SG_MUL: begin
				mul_a = seg_mid;
				mul_b = seg_dur_q;
			end
			ST_VT_MUL: begin
				mul_a = vc_q;
				mul_b = tc_q;
			end
			default: begin
				mul_a = a_q;
				mul_b = a_q;
			end
		endcase
	end

	always_comb begin
		div_start = 1'b0;
		div_num = seg_dv;
		div_den = j_q;
		sqrt_start = 1'b0;
		sqrt_x = div_quo;
		case (state_q)
			ST_TRI_DIV: begin
				div_start = 1'b1;
				div_num = mul_res;
			end
			ST_SG_START: begin
				div_start = 1'b1;
				div_num = (seg_dv < tri_q) ? seg_dv : a_q;
			end
			ST_SG_WAIT1: begin
				if (div_done) begin
					div_start = seg_hit_q;
					sqrt_start = !seg_hit_q;
					div_num = seg_dv - tri_q;
					div_den = a_q;
				end
			end
			ST_EVAL: begin
				div_start = (phase_q == PH_CHECK) && fits_cruise;
				div_num = len_q - d_sum;
				div_den = (max_speed_q == '0) ? Q_W'(1) : max_speed_q;
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	scdp_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num), .den(div_den),
		.busy(div_busy), .done(div_done), .quo(div_quo)
	);

	scdp_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sqrt_start), .x(sqrt_x),
		.busy(sqrt_busy), .done(sqrt_done), .root(sqrt_root)
	);

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= PH_CHECK;
			k_q <= '0;
			seg_sel_q <= 1'b0;
			out_valid_q <= 1'b0;
			max_speed_q <= Q_ONE;
			max_accel_q <= Q_ONE;
			max_jerk_q <= Q_ONE;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_SPEED: max_speed_q <= cfg_data;
					REG_ACCEL: max_accel_q <= cfg_data;
					REG_JERK: max_jerk_q <= cfg_data;
					default: ;
				endcase
			end
			if (out_valid_q && out_ready && (state_q != ST_DONE)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						v0_q <= start_speed;
						len_q <= move_distance;
						a_q <= (max_accel_q == '0) ? Q_W'(1) : max_accel_q;
						j_q <= (max_jerk_q == '0) ? Q_W'(1) : max_jerk_q;
						state_q <= ST_TRI_MUL;
					end
				end
				ST_TRI_MUL: state_q <= ST_TRI_DIV;
				ST_TRI_DIV: state_q <= ST_TRI_WAIT;
				ST_TRI_WAIT: begin
					if (div_done) begin
						tri_q <= div_quo;
						phase_q <= PH_CHECK;
						vp_q <= max_speed_q;
						seg_p_q <= v0_q;
						seg_v_q <= max_speed_q;
						seg_sel_q <= 1'b0;
						state_q <= ST_SG_START;
					end
				end
				ST_SG_START: begin
					seg_hit_q <= !(seg_dv < tri_q);
					state_q <= ST_SG_WAIT1;
				end
				ST_SG_WAIT1: begin
					if (div_done) begin
						seg_jt_q <= div_quo;
						state_q <= seg_hit_q ? ST_SG_WAIT2 : ST_SG_SQRT;
					end
				end
				ST_SG_WAIT2: begin
					if (div_done) begin
						seg_ct_q <= div_quo;
						state_q <= ST_SG_DUR;
					end
				end
				ST_SG_SQRT: begin
					if (sqrt_done) begin
						seg_jt_q <= sqrt_root;
						seg_ct_q <= '0;
						state_q <= ST_SG_DUR;
					end
				end
				ST_SG_DUR: begin
					seg_dur_q <= q_sat({2'b00, seg_jt_q} + {2'b00, seg_jt_q}
						+ {2'b00, seg_ct_q});
					state_q <= ST_SG_MUL;
				end
				ST_SG_MUL: state_q <= ST_SG_DIST;
				ST_SG_DIST: begin
					if (!seg_sel_q) begin
						up_jt_q <= seg_jt_q;
						up_ct_q <= seg_ct_q;
						up_dur_q <= seg_dur_q;
						up_dist_q <= mul_res;
						up_hit_q <= seg_hit_q;
						seg_p_q <= seg_v_q;
						seg_v_q <= '0;
						seg_sel_q <= 1'b1;
						state_q <= ST_SG_START;
					end else begin
						dn_jt_q <= seg_jt_q;
						dn_ct_q <= seg_ct_q;
						dn_dur_q <= seg_dur_q;
						dn_dist_q <= mul_res;
						dn_hit_q <= seg_hit_q;
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					seg_p_q <= v0_q;
					seg_sel_q <= 1'b0;
					case (phase_q)
						PH_CHECK: begin
							if (fits_cruise) begin
								vc_q <= max_speed_q;
								state_q <= ST_TC_WAIT;
							end else begin
								lo_q <= init_lo;
								hi_q <= init_hi;
								k_q <= '0;
								vp_q <= q_mid(init_lo, init_hi);
								seg_v_q <= q_mid(init_lo, init_hi);
								phase_q <= PH_BISECT;
								state_q <= ST_SG_START;
							end
						end
						PH_BISECT: begin
							lo_q <= bis_lo;
							hi_q <= bis_hi;
							k_q <= k_q + 1'b1;
							vp_q <= q_mid(bis_lo, bis_hi);
							seg_v_q <= q_mid(bis_lo, bis_hi);
							if (k_q == KW'(BISECT_STEPS - 1)) begin
								phase_q <= PH_FINAL;
							end
							state_q <= ST_SG_START;
						end
						default: begin
							vc_q <= vp_q;
							tc_q <= '0;
							state_q <= ST_VT_MUL;
						end
					endcase
				end
				ST_TC_WAIT: begin
					if (div_done) begin
						tc_q <= div_quo;
						state_q <= ST_VT_MUL;
					end
				end
				ST_VT_MUL: state_q <= ST_TOT;
				ST_TOT: begin
					tot_d_q <= q_sat({2'b00, up_dist_q} + {2'b00, mul_res} + {2'b00, dn_dist_q});
					tot_t_q <= q_sat({2'b00, up_dur_q} + {2'b00, tc_q} + {2'b00, dn_dur_q});
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!out_valid_q || out_ready) begin
						peak_speed <= vc_q;
						cruise_time <= tc_q;
						accel_jerk_time <= up_jt_q;
						accel_const_time <= up_ct_q;
						decel_jerk_time <= dn_jt_q;
						decel_const_time <= dn_ct_q;
						accel_hit_limit <= up_hit_q;
						decel_hit_limit <= dn_hit_q;
						accel_distance <= up_dist_q;
						decel_distance <= dn_dist_q;
						total_distance <= tot_d_q;
						total_time <= tot_t_q;
						out_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	`ASSERT_NEVER(a_div_start_busy, div_start && (div_busy || sqrt_busy), "divider restarted while busy")
	`ASSERT_NEVER(a_sqrt_start_busy, sqrt_start && (sqrt_busy || div_busy), "root restarted while busy")
	`ASSERT_CLK(a_k_bound, k_q <= KW'(BISECT_STEPS), "bisection count out of range")
	`ASSERT_CLK(a_done_idle, (state_q == ST_DONE) && !out_valid_q |=> out_valid_q && (state_q == ST_IDLE), "finished item not delivered")
endmodule

// ----- sv/scdp_div.sv -----
// ----------------------------------------------------------------------------
// Fixed-point divider
// Restoring divider, one quotient bit per cycle, returns (num << F) / den
// saturated to 32 bits; a zero divisor gives zero or full scale.
// ----------------------------------------------------------------------------
module scdp_div
	import scdp_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [Q_W-1:0] num,
	input  logic [Q_W-1:0] den,
	output logic           busy,
	output logic           done,
	output logic [Q_W-1:0] quo
);
	localparam int DW = Q_W + FRAC_BITS;
	localparam int CW = $clog2(DW + 1);

	logic [DW-1:0]  dvd_q;
	logic [Q_W-1:0] rem_q;
	logic [Q_W-1:0] den_q;
	logic [CW-1:0]  cnt_q;
	logic           busy_q;
	logic           done_q;
	logic [Q_W:0]   trial;
	logic           ge;

	assign trial = {rem_q, dvd_q[DW-1]};
	assign ge = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				if (den == '0) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
					cnt_q <= CW'(DW);
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= den;
			rem_q <= '0;
			if (den == '0) begin
				dvd_q <= (num == '0) ? '0 : DW'(Q_MAX);
			end else begin
				dvd_q <= {num, {FRAC_BITS{1'b0}}};
			end
		end else if (busy_q) begin
			rem_q <= ge ? Q_W'(trial - {1'b0, den_q}) : trial[Q_W-1:0];
			dvd_q <= {dvd_q[DW-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quo = (|dvd_q[DW-1:Q_W]) ? Q_MAX : dvd_q[Q_W-1:0];
endmodule

// ----- sv/scdp_sqrt.sv -----
// ----------------------------------------------------------------------------
// Fixed-point square root
// Digit-by-digit root of (x << F), one result bit per cycle, floor rounding.
// ----------------------------------------------------------------------------
module scdp_sqrt
	import scdp_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [Q_W-1:0] x,
	output logic           busy,
	output logic           done,
	output logic [Q_W-1:0] root
);
	localparam int NW = 2 * ((Q_W + FRAC_BITS + 1) / 2);
	localparam int R = NW / 2;
	localparam int CW = $clog2(R + 1);

	logic [NW-1:0] n_q;
	logic [R+1:0]  rem_q;
	logic [R-1:0]  root_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [R+1:0]  shifted;
	logic [R+1:0]  trial;
	logic          ge;

	assign shifted = {rem_q[R-1:0], n_q[NW-1:NW-2]};
	assign trial = {root_q, 2'b01};
	assign ge = shifted >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(R);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= NW'({x, {FRAC_BITS{1'b0}}});
			rem_q <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			n_q <= {n_q[NW-3:0], 2'b00};
			rem_q <= ge ? (shifted - trial) : shifted;
			root_q <= {root_q[R-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign root = Q_W'(root_q);
endmodule
